[rtl/erpp_pkg.sv]
package erpp_pkg;

    localparam int          SINE_TABLE_DEPTH_DEF = 256;
    localparam int          COORD_WIDTH_DEF      = 16;
    localparam logic [63:0] PI_HALF_Q30          = 64'd1686629713;

    localparam int DVS_W  = 22;
    localparam int DIVD_W = 38;

    typedef enum logic [2:0] {
        REG_ANGLE_A  = 3'd0,
        REG_ANGLE_B  = 3'd1,
        REG_ANGLE_C  = 3'd2,
        REG_DISTANCE = 3'd3,
        REG_SCALE    = 3'd4,
        REG_CENTER_X = 3'd5,
        REG_CENTER_Y = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [DVS_W-1:0]  rem;
        logic [DIVD_W-1:0] nq;
    } div_lane_t;

    function automatic logic [15:0] sine_entry(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        longint      q;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 6; k++)
        begin
            term = (term * x2) >> 30;
            case (k)
                1:       term = term / 6;
                2:       term = term / 20;
                3:       term = term / 42;
                4:       term = term / 72;
                5:       term = term / 110;
                default: term = term / 156;
            endcase
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        q = (sum + 16384) >>> 15;
        if (q > 32768)
            q = 32768;
        return q[15:0];
    endfunction

    function automatic logic [31:0] rom_index(input logic [15:0] angle, input int depth);
        logic [31:0] base;
        if (angle[14])
            base = 32'd16384 - {18'd0, angle[13:0]};
        else
            base = {18'd0, angle[13:0]};
        return (base * 32'(depth)) >> 14;
    endfunction

    function automatic logic [15:0] saturate(input logic signed [63:0] v, input int bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
            return hi[15:0];
        else if (v < lo)
            return lo[15:0];
        else
            return v[15:0];
    endfunction

    function automatic div_lane_t div_step(input div_lane_t s, input logic [DVS_W-1:0] dvs);
        div_lane_t        r;
        logic [DVS_W:0]   t;
        logic             ge;
        t  = {s.rem, s.nq[DIVD_W-1]};
        ge = (t >= {1'b0, dvs});
        if (ge)
            r.rem = DVS_W'(t - {1'b0, dvs});
        else
            r.rem = t[DVS_W-1:0];
        r.nq = {s.nq[DIVD_W-2:0], ge};
        return r;
    endfunction

endpackage

[rtl/euler_rotate_perspective_project.sv]
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+-------------------------------
// vertex    | pos_x, pos_y, pos_z                     | word taken when start && !busy
// result    | rot_x/y/z, screen_x/y, behind_camera    | word valid for one cycle on done
// config    | wr_en, wr_index, wr_data                | written when wr_en is high
//
// One vertex per cycle while busy is low; results come out in the order the vertices were taken.
// Most of the pipeline is the two restoring dividers, one quotient bit per stage.
// busy is high only during reset and for the first cycle after it.
// The pipeline never stalls; results cannot be held off by the receiver.
module euler_rotate_perspective_project
    import erpp_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic               wr_en,
    input  logic [2:0]         wr_index,
    input  logic [15:0]        wr_data,
    output logic               done,
    output logic signed [15:0] rot_x,
    output logic signed [15:0] rot_y,
    output logic signed [15:0] rot_z,
    output logic signed [15:0] screen_x,
    output logic signed [15:0] screen_y,
    output logic               behind_camera
);

    localparam int IDXW     = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SAT_BITS = (COORD_WIDTH > 16) ? 16 : COORD_WIDTH;
    localparam int NSTEP    = DIVD_W;
    localparam int LAT      = 9 + NSTEP;

    typedef struct packed {
        logic [DVS_W-1:0] dvs;
        div_lane_t        lx;
        div_lane_t        ly;
        logic             neg_x;
        logic             neg_y;
        logic             behind;
        logic [15:0]      rx;
        logic [15:0]      ry;
        logic [15:0]      rz;
    } div_stage_t;

    // configuration
    logic [15:0] angle_a_reg, angle_b_reg, angle_c_reg;
    logic [11:0] distance_reg, center_x_reg, center_y_reg;
    logic [7:0]  scale_reg;
    logic        busy_reg, busy_next;
    logic [LAT-1:0] vld_reg, vld_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_a_reg  <= '0;
            angle_b_reg  <= '0;
            angle_c_reg  <= '0;
            distance_reg <= 12'd1000;
            scale_reg    <= 8'd20;
            center_x_reg <= 12'd500;
            center_y_reg <= 12'd400;
            busy_reg     <= 1'b1;
            vld_reg      <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            vld_reg  <= vld_next;
            if (wr_en)
            begin
                case (reg_index_t'(wr_index))
                    REG_ANGLE_A:  angle_a_reg  <= wr_data;
                    REG_ANGLE_B:  angle_b_reg  <= wr_data;
                    REG_ANGLE_C:  angle_c_reg  <= wr_data;
                    REG_DISTANCE: distance_reg <= wr_data[11:0];
                    REG_SCALE:    scale_reg    <= wr_data[7:0];
                    REG_CENTER_X: center_x_reg <= wr_data[11:0];
                    REG_CENTER_Y: center_y_reg <= wr_data[11:0];
                    default:      ;
                endcase
            end
        end
    end

    assign busy_next = 1'b0;
    assign busy      = busy_reg;
    assign vld_next  = {vld_reg[LAT-2:0], start && !busy_reg};
    assign done      = vld_reg[LAT-1];

    // sine table
    logic [15:0] rom [0:SINE_TABLE_DEPTH];
    for (genvar n = 0; n <= SINE_TABLE_DEPTH; n++)
    begin : g_rom
        localparam logic [63:0] XN = (PI_HALF_Q30 * 64'(n)) / SINE_TABLE_DEPTH;
        assign rom[n] = sine_entry(XN);
    end

    logic [15:0]        ang [0:5];
    logic signed [16:0] trig [0:5];
    assign ang[0] = angle_a_reg;
    assign ang[1] = 16'(angle_a_reg + 16'd16384);
    assign ang[2] = angle_b_reg;
    assign ang[3] = 16'(angle_b_reg + 16'd16384);
    assign ang[4] = angle_c_reg;
    assign ang[5] = 16'(angle_c_reg + 16'd16384);

    for (genvar t = 0; t < 6; t++)
    begin : g_trig
        logic [31:0]        idx;
        logic signed [16:0] mag;
        assign idx     = rom_index(ang[t], SINE_TABLE_DEPTH);
        assign mag     = $signed({1'b0, rom[idx[IDXW-1:0]]});
        assign trig[t] = ang[t][15] ? -mag : mag;
    end

    // coefficient pipeline, free running from the registers
    logic signed [16:0] sa_reg, ca_reg, sb_reg, cb_reg, sc_reg, cc_reg;
    logic [19:0]        ds_reg;
    logic [11:0]        d_reg;
    logic signed [33:0] sasb_reg, casb_reg, casc_reg, sasc_reg, cacc_reg, sacc_reg;
    logic signed [33:0] cbcc_reg, cbsc_reg, sacb_reg, cacb_reg;
    logic signed [16:0] sb2_reg, cc2_reg, sc2_reg;
    logic signed [33:0] t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [33:0] casc3_reg, sasc3_reg, cacc3_reg, sacc3_reg;
    logic signed [33:0] cbcc3_reg, cbsc3_reg, sacb3_reg, cacb3_reg;
    logic signed [16:0] sb3_reg;
    logic signed [34:0] cxi_reg, cxj_reg, cxk_reg, cyi_reg, cyj_reg, cyk_reg;
    logic signed [34:0] czi_reg, czj_reg, czk_reg;
    logic signed [50:0] p1, p2, p3, p4;
    logic [11:0]        d_eff;

    assign d_eff = (distance_reg == 12'd0) ? 12'd1 : distance_reg;
    assign p1    = sasb_reg * cc2_reg;
    assign p2    = casb_reg * cc2_reg;
    assign p3    = sasb_reg * sc2_reg;
    assign p4    = casb_reg * sc2_reg;

    always_ff @(posedge clk)
    begin
        sa_reg <= trig[0];
        ca_reg <= trig[1];
        sb_reg <= trig[2];
        cb_reg <= trig[3];
        sc_reg <= trig[4];
        cc_reg <= trig[5];
        d_reg  <= d_eff;
        ds_reg <= d_eff * scale_reg;

        sasb_reg <= sa_reg * sb_reg;
        casb_reg <= ca_reg * sb_reg;
        casc_reg <= ca_reg * sc_reg;
        sasc_reg <= sa_reg * sc_reg;
        cacc_reg <= ca_reg * cc_reg;
        sacc_reg <= sa_reg * cc_reg;
        cbcc_reg <= cb_reg * cc_reg;
        cbsc_reg <= cb_reg * sc_reg;
        sacb_reg <= sa_reg * cb_reg;
        cacb_reg <= ca_reg * cb_reg;
        sb2_reg  <= sb_reg;
        cc2_reg  <= cc_reg;
        sc2_reg  <= sc_reg;

        t1_reg    <= 34'((p1 + 51'sd16384) >>> 15);
        t2_reg    <= 34'((p2 + 51'sd16384) >>> 15);
        t3_reg    <= 34'((p3 + 51'sd16384) >>> 15);
        t4_reg    <= 34'((p4 + 51'sd16384) >>> 15);
        casc3_reg <= casc_reg;
        sasc3_reg <= sasc_reg;
        cacc3_reg <= cacc_reg;
        sacc3_reg <= sacc_reg;
        cbcc3_reg <= cbcc_reg;
        cbsc3_reg <= cbsc_reg;
        sacb3_reg <= sacb_reg;
        cacb3_reg <= cacb_reg;
        sb3_reg   <= sb2_reg;

        cxi_reg <= 35'(cbcc3_reg);
        cxj_reg <= 35'(t1_reg) + 35'(casc3_reg);
        cxk_reg <= 35'(sasc3_reg) - 35'(t2_reg);
        cyi_reg <= -35'(cbsc3_reg);
        cyj_reg <= 35'(cacc3_reg) - 35'(t3_reg);
        cyk_reg <= 35'(sacc3_reg) + 35'(t4_reg);
        czi_reg <= 35'(sb3_reg) <<< 15;
        czj_reg <= -35'(sacb3_reg);
        czk_reg <= 35'(cacb3_reg);
    end

    // vertex pipeline
    logic signed [15:0] px_reg [0:3];
    logic signed [15:0] py_reg [0:3];
    logic signed [15:0] pz_reg [0:3];
    logic signed [50:0] m_reg [0:8];
    logic signed [52:0] sum_x, sum_y, sum_z;
    logic [15:0]        rx_reg, ry_reg, rz_reg;
    logic signed [36:0] nx_reg, ny_reg;
    logic signed [21:0] den_reg;
    logic [15:0]        rx7_reg, ry7_reg, rz7_reg;
    logic               behind7_reg;
    logic signed [21:0] den_next;
    div_stage_t         dv_reg [0:NSTEP];

    assign sum_x    = 53'(m_reg[0]) + 53'(m_reg[1]) + 53'(m_reg[2]) + 53'sd536870912;
    assign sum_y    = 53'(m_reg[3]) + 53'(m_reg[4]) + 53'(m_reg[5]) + 53'sd536870912;
    assign sum_z    = 53'(m_reg[6]) + 53'(m_reg[7]) + 53'(m_reg[8]) + 53'sd536870912;
    assign den_next = 22'($signed(rz_reg)) + $signed({2'b00, d_reg, 8'd0});

    always_ff @(posedge clk)
    begin
        px_reg[0] <= pos_x;
        py_reg[0] <= pos_y;
        pz_reg[0] <= pos_z;
        for (int s = 1; s < 4; s++)
        begin
            px_reg[s] <= px_reg[s-1];
            py_reg[s] <= py_reg[s-1];
            pz_reg[s] <= pz_reg[s-1];
        end

        m_reg[0] <= px_reg[3] * cxi_reg;
        m_reg[1] <= py_reg[3] * cxj_reg;
        m_reg[2] <= pz_reg[3] * cxk_reg;
        m_reg[3] <= px_reg[3] * cyi_reg;
        m_reg[4] <= py_reg[3] * cyj_reg;
        m_reg[5] <= pz_reg[3] * cyk_reg;
        m_reg[6] <= px_reg[3] * czi_reg;
        m_reg[7] <= py_reg[3] * czj_reg;
        m_reg[8] <= pz_reg[3] * czk_reg;

        rx_reg <= saturate(64'(sum_x >>> 30), SAT_BITS);
        ry_reg <= saturate(64'(sum_y >>> 30), SAT_BITS);
        rz_reg <= saturate(64'(sum_z >>> 30), SAT_BITS);

        nx_reg      <= $signed(rx_reg) * $signed({1'b0, ds_reg});
        ny_reg      <= $signed(ry_reg) * $signed({1'b0, ds_reg});
        den_reg     <= den_next;
        behind7_reg <= den_next[21] || (den_next == 22'sd0);
        rx7_reg     <= rx_reg;
        ry7_reg     <= ry_reg;
        rz7_reg     <= rz_reg;
    end

    // load the dividers: q = (2|num| + den) / (2 den)
    logic [35:0] mag_x, mag_y;
    assign mag_x = 36'(nx_reg[36] ? -nx_reg : nx_reg);
    assign mag_y = 36'(ny_reg[36] ? -ny_reg : ny_reg);

    always_ff @(posedge clk)
    begin
        dv_reg[0].dvs    <= {den_reg[20:0], 1'b0};
        dv_reg[0].lx.rem <= '0;
        dv_reg[0].lx.nq  <= {1'b0, mag_x, 1'b0} + DIVD_W'(den_reg[20:0]);
        dv_reg[0].ly.rem <= '0;
        dv_reg[0].ly.nq  <= {1'b0, mag_y, 1'b0} + DIVD_W'(den_reg[20:0]);
        dv_reg[0].neg_x  <= nx_reg[36];
        dv_reg[0].neg_y  <= ny_reg[36];
        dv_reg[0].behind <= behind7_reg;
        dv_reg[0].rx     <= rx7_reg;
        dv_reg[0].ry     <= ry7_reg;
        dv_reg[0].rz     <= rz7_reg;
    end

    for (genvar g = 0; g < NSTEP; g++)
    begin : g_div
        div_stage_t st_next;
        always_comb
        begin
            st_next    = dv_reg[g];
            st_next.lx = div_step(dv_reg[g].lx, dv_reg[g].dvs);
            st_next.ly = div_step(dv_reg[g].ly, dv_reg[g].dvs);
        end
        always_ff @(posedge clk)
        begin
            dv_reg[g+1] <= st_next;
        end
    end

    // output register
    logic signed [39:0] qx, qy;
    logic [15:0]        sx_next, sy_next;
    logic [15:0]        rot_x_reg, rot_y_reg, rot_z_reg, sx_reg, sy_reg;
    logic               behind_reg;

    always_comb
    begin
        qx = $signed({2'b00, dv_reg[NSTEP].lx.nq});
        qy = $signed({2'b00, dv_reg[NSTEP].ly.nq});
        if (dv_reg[NSTEP].neg_x)
            qx = -qx;
        if (dv_reg[NSTEP].neg_y)
            qy = -qy;
        sx_next = saturate(64'(qx + $signed({28'd0, center_x_reg})), SAT_BITS);
        sy_next = saturate(64'(qy + $signed({28'd0, center_y_reg})), SAT_BITS);
        if (dv_reg[NSTEP].behind)
        begin
            sx_next = '0;
            sy_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        rot_x_reg  <= dv_reg[NSTEP].rx;
        rot_y_reg  <= dv_reg[NSTEP].ry;
        rot_z_reg  <= dv_reg[NSTEP].rz;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        behind_reg <= dv_reg[NSTEP].behind;
    end

    assign rot_x         = rot_x_reg;
    assign rot_y         = rot_y_reg;
    assign rot_z         = rot_z_reg;
    assign screen_x      = sx_reg;
    assign screen_y      = sy_reg;
    assign behind_camera = behind_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(LAT) done)
        else $error("result missing after accepted word");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !$past(busy, LAT)) |-> $past(start, LAT))
        else $error("result without accepted word");

    a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && behind_camera) |-> (screen_x == 16'sd0 && screen_y == 16'sd0))
        else $error("screen fields not cleared behind camera");

    a_busy_release: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy raised after release");

endmodule

[sim/vertex_projection_checker.sv]
module vertex_projection_checker
    import erpp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    input  logic               wr_en,
    input  logic [2:0]         wr_index,
    input  logic [15:0]        wr_data,
    input  logic               done,
    input  logic signed [15:0] rot_x,
    input  logic signed [15:0] rot_y,
    input  logic signed [15:0] rot_z,
    input  logic signed [15:0] screen_x,
    input  logic signed [15:0] screen_y,
    input  logic               behind_camera,
    output int                 errors,
    output int                 pending,
    output int                 points_seen,
    output int                 behind_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 256;

    typedef struct {
        logic signed [15:0] rx;
        logic signed [15:0] ry;
        logic signed [15:0] rz;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic               behind;
    } screen_point_t;

    longint        quarter_sine [0:DEPTH];
    screen_point_t expected_points [$];

    logic [15:0] ang_a, ang_b, ang_c;
    logic [11:0] view_distance, ctr_x, ctr_y;
    logic [7:0]  scale;

    initial
    begin
        longint x, x2, term, sum, q;
        errors = 0;
        pending = 0;
        points_seen = 0;
        behind_seen = 0;
        for (int n = 0; n <= DEPTH; n++)
        begin
            x = (64'd1686629713 * n) / DEPTH;
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int k = 1; k <= 6; k++)
            begin
                term = (term * x2) >> 30;
                term = term / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            if (sum < 0)
                sum = 0;
            q = (sum + 16384) >>> 15;
            quarter_sine[n] = (q > 32768) ? 32768 : q;
        end
    end

    function automatic longint sin_q15(input logic [15:0] angle);
        longint idx;
        if (angle[14])
            idx = ((16384 - longint'(angle[13:0])) * DEPTH) >>> 14;
        else
            idx = (longint'(angle[13:0]) * DEPTH) >>> 14;
        if (idx > DEPTH)
            idx = DEPTH;
        return angle[15] ? -quarter_sine[idx] : quarter_sine[idx];
    endfunction

    function automatic longint cos_q15(input logic [15:0] angle);
        logic [15:0] shifted;
        shifted = angle + 16'd16384;
        return sin_q15(shifted);
    endfunction

    function automatic longint round_down(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] to_screen(input longint r, input longint d,
                                                     input longint den, input longint ctr);
        longint num, mag, q;
        num = r * d * longint'(scale);
        mag = (num < 0) ? -num : num;
        q = (mag * 2 + den) / (den * 2);
        if (num < 0)
            q = -q;
        return clamp16(q + ctr);
    endfunction

    function automatic screen_point_t transform_vertex(input longint i, input longint j,
                                                       input longint k);
        screen_point_t p;
        longint sa, ca, sb, cb, sc, cc;
        longint xi, xj, xk, yi, yj, yk, zi, zj, zk, d, den;
        sa = sin_q15(ang_a); ca = cos_q15(ang_a);
        sb = sin_q15(ang_b); cb = cos_q15(ang_b);
        sc = sin_q15(ang_c); cc = cos_q15(ang_c);
        xi = cb * cc;
        xj = round_down(sa * sb * cc, 15) + ca * sc;
        xk = -round_down(ca * sb * cc, 15) + sa * sc;
        yi = -(cb * sc);
        yj = ca * cc - round_down(sa * sb * sc, 15);
        yk = sa * cc + round_down(ca * sb * sc, 15);
        zi = sb * 32768;
        zj = -(sa * cb);
        zk = ca * cb;
        p.rx = clamp16(round_down(i * xi + j * xj + k * xk, 30));
        p.ry = clamp16(round_down(i * yi + j * yj + k * yk, 30));
        p.rz = clamp16(round_down(i * zi + j * zj + k * zk, 30));
        d = (view_distance == 0) ? 1 : longint'(view_distance);
        den = longint'(p.rz) + 256 * d;
        p.behind = (den <= 0);
        p.sx = 0;
        p.sy = 0;
        if (!p.behind)
        begin
            p.sx = to_screen(p.rx, d, den, ctr_x);
            p.sy = to_screen(p.ry, d, den, ctr_y);
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_a <= 0; ang_b <= 0; ang_c <= 0;
            view_distance <= 1000; scale <= 20; ctr_x <= 500; ctr_y <= 400;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ANGLE_A:  ang_a <= wr_data;
                REG_ANGLE_B:  ang_b <= wr_data;
                REG_ANGLE_C:  ang_c <= wr_data;
                REG_DISTANCE: view_distance <= wr_data[11:0];
                REG_SCALE:    scale <= wr_data[7:0];
                REG_CENTER_X: ctr_x <= wr_data[11:0];
                REG_CENTER_Y: ctr_y <= wr_data[11:0];
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        screen_point_t want;
        if (rst_n && done)
        begin
            points_seen++;
            if (expected_points.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                want = expected_points.pop_front();
                if (behind_camera)
                    behind_seen++;
                if (rot_x !== want.rx) report_mismatch("rot_x", rot_x, want.rx);
                if (rot_y !== want.ry) report_mismatch("rot_y", rot_y, want.ry);
                if (rot_z !== want.rz) report_mismatch("rot_z", rot_z, want.rz);
                if (screen_x !== want.sx) report_mismatch("screen_x", screen_x, want.sx);
                if (screen_y !== want.sy) report_mismatch("screen_y", screen_y, want.sy);
                if (behind_camera !== want.behind)
                    report_mismatch("behind_camera", behind_camera, want.behind);
            end
        end
        if (rst_n && start && !busy)
            expected_points.push_back(transform_vertex(pos_x, pos_y, pos_z));
        pending <= expected_points.size();
    end

endmodule

[sim/euler_rotate_perspective_project_test.sv]
module euler_rotate_perspective_project_test;
    import erpp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAT = 47;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic               clk, rst_n, start, busy, wr_en, done, behind_camera;
    logic signed [15:0] pos_x, pos_y, pos_z;
    logic [2:0]         wr_index;
    logic [15:0]        wr_data;
    logic signed [15:0] rot_x, rot_y, rot_z, screen_x, screen_y;
    int                 errors, pending, points_seen, behind_seen;
    int                 cycles, idle_pct, sent;

    euler_rotate_perspective_project dut (.*);

    vertex_projection_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("euler_rotate_perspective_project_test failed");
                $finish;
            end
        end
    end

    task automatic drain();
        start <= 0;
        wait (pending == 0);
        repeat (LAT + 5) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        wr_en <= 1;
        wr_index <= idx;
        wr_data <= val;
        @(negedge clk);
        wr_en <= 0;
    endtask

    task automatic send_vertex(input logic signed [15:0] x, input logic signed [15:0] y,
                               input logic signed [15:0] z);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        start <= 1;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        do
            @(posedge clk);
        while (busy);
        sent++;
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       return 16'($signed($urandom_range(4096)) - 2048);
            2:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(600)) - 300);
        endcase
    endfunction

    task automatic random_settings();
        write_reg(REG_ANGLE_A, 16'($urandom));
        write_reg(REG_ANGLE_B, 16'($urandom));
        write_reg(REG_ANGLE_C, 16'($urandom));
        write_reg(REG_DISTANCE,
                  16'($urandom_range(1) ? $urandom_range(4095) : $urandom_range(8)));
        write_reg(REG_SCALE, 16'($urandom_range(255)));
        write_reg(REG_CENTER_X, 16'($urandom_range(4095)));
        write_reg(REG_CENTER_Y, 16'($urandom_range(4095)));
    endtask

    initial
    begin
        logic [15:0] angle_set [5];
        angle_set = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535};
        rst_n = 0; start = 0; wr_en = 0; wr_index = 0; wr_data = 0;
        pos_x = 0; pos_y = 0; pos_z = 0;
        idle_pct = 0; sent = 0;
        repeat (6) @(negedge clk);
        rst_n = 1;

        send_vertex(16'sd0, 16'sd0, 16'sd0);
        send_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_vertex(16'sh8000, 16'sh8000, 16'sh8000);
        send_vertex(16'sh7fff, 16'sh8000, 16'sd0);
        send_vertex(16'sd256, -16'sd256, 16'sd512);
        drain();
        write_reg(REG_DISTANCE, 16'd1);
        write_reg(REG_UNUSED, 16'hffff);
        send_vertex(16'sd100, 16'sd100, -16'sd256);
        send_vertex(16'sd100, 16'sd100, -16'sd255);
        send_vertex(16'sd100, 16'sd100, -16'sd257);
        send_vertex(16'sh7fff, 16'sh8000, 16'sh8000);
        drain();
        write_reg(REG_DISTANCE, 16'd0);
        write_reg(REG_SCALE, 16'd255);
        write_reg(REG_CENTER_X, 16'd4095);
        write_reg(REG_CENTER_Y, 16'd0);
        send_vertex(16'sh7fff, 16'sh8000, 16'sd0);
        send_vertex(-16'sd300, 16'sd300, -16'sd200);
        drain();
        for (int a = 0; a < 5; a++)
        begin
            write_reg(REG_ANGLE_A, angle_set[a]);
            write_reg(REG_ANGLE_B, angle_set[(a + 1) % 5]);
            write_reg(REG_ANGLE_C, angle_set[(a + 3) % 5]);
            write_reg(REG_DISTANCE, 16'd4095);
            write_reg(REG_SCALE, 16'd0);
            send_vertex(16'sh7fff, 16'sh8000, 16'sh7fff);
            drain();
            write_reg(REG_SCALE, 16'd255);
            send_vertex(16'sh4000, -16'sh1234, 16'sh0321);
            drain();
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 57;
                2: idle_pct = 0;
                default: idle_pct = 38;
            endcase
            random_settings();
            for (int n = 0; n < 210; n++)
            begin
                send_vertex(pick_coord(), pick_coord(), pick_coord());
                if (ph == 3 && n == 100)
                    drain();
            end
            drain();
        end

        wait (pending == 0);
        repeat (LAT + 10) @(posedge clk);
        $display("sent %0d vertices over default, extreme and random settings", sent);
        $display("checked %0d results, %0d of them behind the camera", points_seen,
                 behind_seen);
        if (errors == 0)
            $display("euler_rotate_perspective_project_test passed");
        else
            $display("euler_rotate_perspective_project_test failed");
        $finish;
    end

endmodule
